FILE: src/madc_pkg.sv
// shared types, constants and the arctangent table of the angle defect block
package madc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 24;
  localparam int POS_W        = 3 * COORD_W;
  localparam int ACC_W        = 32;
  localparam int SQ_W         = 51;
  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 30;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FACE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic signed [31:0] Q24_TWO_PI  = 32'sd105414357;
  localparam logic signed [31:0] Q24_PI      = 32'sd52707179;
  localparam logic signed [31:0] Q24_HALF_PI = 32'sd26353589;

  typedef enum logic [1:0] {
    K_NOP  = 2'd0,
    K_LOAD = 2'd1,
    K_FACE = 2'd2,
    K_READ = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   ia;
    logic [IDX_W-1:0]   ib;
    logic [IDX_W-1:0]   ic;
    logic [POS_W-1:0]   pos;
  } cmd_t;

  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd13176795;
      5'd1:    v = 32'sd7778716;
      5'd2:    v = 32'sd4110060;
      5'd3:    v = 32'sd2086331;
      5'd4:    v = 32'sd1047214;
      5'd5:    v = 32'sd524117;
      5'd6:    v = 32'sd262123;
      5'd7:    v = 32'sd131069;
      5'd8:    v = 32'sd65536;
      5'd9:    v = 32'sd32768;
      5'd10:   v = 32'sd16384;
      5'd11:   v = 32'sd8192;
      5'd12:   v = 32'sd4096;
      5'd13:   v = 32'sd2048;
      5'd14:   v = 32'sd1024;
      5'd15:   v = 32'sd512;
      5'd16:   v = 32'sd256;
      5'd17:   v = 32'sd128;
      5'd18:   v = 32'sd64;
      5'd19:   v = 32'sd32;
      5'd20:   v = 32'sd16;
      5'd21:   v = 32'sd8;
      5'd22:   v = 32'sd4;
      5'd23:   v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/madc_if.sv
// item and result channel interfaces
interface madc_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [9:0]         index_a;
  logic [9:0]         index_b;
  logic [9:0]         index_c;
  logic signed [23:0] coord_x;
  logic signed [23:0] coord_y;
  logic signed [23:0] coord_z;

  modport source (output valid, operation, index_a, index_b, index_c,
                  coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, operation, index_a, index_b, index_c,
                coord_x, coord_y, coord_z, output ready);
endinterface

interface madc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curvature;
  logic               degenerate_face;
  logic               saturated;

  modport source (output valid, curvature, degenerate_face, saturated, input ready);
  modport sink (input valid, curvature, degenerate_face, saturated, output ready);
endinterface

FILE: src/madc_front.sv
// front end: accepts words, classifies them and queues commands
module madc_front (
  input  logic          clk,
  input  logic          rst,
  madc_item_if.sink     item,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output madc_pkg::cmd_t cmd
);
  import madc_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       a_ok, b_ok, c_ok;
  logic       push, pop;

  always_comb begin
    a_ok    = 32'(item.index_a) < MAX_VERTICES;
    b_ok    = 32'(item.index_b) < MAX_VERTICES;
    c_ok    = 32'(item.index_c) < MAX_VERTICES;
    cls.ia  = item.index_a;
    cls.ib  = item.index_b;
    cls.ic  = item.index_c;
    cls.pos = {item.coord_x, item.coord_y, item.coord_z};
    unique case (item.operation)
      OP_LOAD: cls.kind = a_ok ? K_LOAD : K_NOP;
      OP_FACE: cls.kind = (a_ok && b_ok && c_ok) ? K_FACE : K_NOP;
      OP_READ: cls.kind = a_ok ? K_READ : K_NOP;
      default: cls.kind = K_NOP;
    endcase
  end

  assign item.ready = count != 2'd2;
  assign push       = item.valid && item.ready;
  assign cmd_valid  = count != 2'd0;
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

endmodule

FILE: src/madc_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module madc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitm;
  logic        busy;
  logic [63:0] trial;
  logic        ge;

  assign trial = res + bitm;
  assign ge    = v >= trial;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= arg;
        res  <= 64'd0;
        bitm <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          v   <= v - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/madc_back.sv
// back end: vertex stores, face angle sequencer and result register
module madc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  madc_pkg::cmd_t cmd,
  madc_result_if.source  result
);
  import madc_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_RDACC = 16'h0002,
    S_FETCH = 16'h0004,
    S_EDGE  = 16'h0008,
    S_LEN   = 16'h0010,
    S_LENW  = 16'h0020,
    S_MUL   = 16'h0040,
    S_NUM   = 16'h0080,
    S_DIV   = 16'h0100,
    S_SQ    = 16'h0200,
    S_SIN   = 16'h0400,
    S_SINW  = 16'h0800,
    S_ROT   = 16'h1000,
    S_ACCRD = 16'h2000,
    S_ACCWR = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  state_t state;

  logic [POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [POS_W-1:0] pos_q;
  logic [ACC_W-1:0] acc_q;
  logic [IDX_W-1:0] pos_raddr, acc_raddr, acc_waddr;
  logic [ACC_W-1:0] acc_wdata;
  logic             pos_we, acc_we;

  logic [IDX_W-1:0] idx [3];
  logic [POS_W-1:0] p [3];
  logic [SQ_W-1:0]  sq [3];
  logic [30:0]      len [3];
  logic [1:0]       fcnt, ed, cp, k;
  logic             ph;
  logic [49:0]      prod;
  logic [61:0]      den;
  logic             num_neg;
  logic [63:0]      n, r;
  logic [29:0]      q;
  logic [30:0]      cmag;
  logic [61:0]      csq;
  logic signed [35:0] x, y;
  logic signed [31:0] z;
  logic [4:0]       step;
  logic signed [31:0] pend_curv;
  logic             pend_degen, pend_sat;
  logic             res_valid;
  logic signed [31:0] res_curv;
  logic             res_degen, res_sat;

  logic [1:0]       ej, ek, kb, kc;
  logic signed [23:0] cj, ck;
  logic signed [24:0] d;
  logic signed [49:0] dd;
  logic             any_zero;
  logic             sq_start, sq_done;
  logic [63:0]      sq_arg;
  logic [31:0]      sq_root;
  logic signed [52:0] numv, mag;
  logic [63:0]      r2, den64;
  logic             dge;
  logic signed [35:0] xs, ys;
  logic signed [31:0] zc, atan_v;
  logic signed [32:0] accr;
  logic             clip;

  function automatic logic [1:0] nxt(input logic [1:0] v);
    logic [1:0] o;
    case (v)
      2'd0:    o = 2'd1;
      2'd1:    o = 2'd2;
      default: o = 2'd0;
    endcase
    return o;
  endfunction

  function automatic logic signed [23:0] comp(input logic [POS_W-1:0] v,
                                              input logic [1:0] c);
    logic signed [23:0] o;
    case (c)
      2'd0:    o = v[71:48];
      2'd1:    o = v[47:24];
      default: o = v[23:0];
    endcase
    return o;
  endfunction

  madc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .arg   (sq_arg),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_comb begin
    ej       = nxt(ed);
    ek       = nxt(nxt(ed));
    kb       = nxt(k);
    kc       = nxt(nxt(k));
    cj       = comp(p[ej], cp);
    ck       = comp(p[ek], cp);
    d        = {cj[23], cj} - {ck[23], ck};
    dd       = d * d;
    any_zero = (sq[0] == '0) || (sq[1] == '0) || (sq[2] == '0);
    numv     = $signed({2'b00, sq[kb]}) + $signed({2'b00, sq[kc]})
             - $signed({2'b00, sq[k]});
    mag      = numv[52] ? -numv : numv;
    den64    = {2'b00, den};
    r2       = {r[62:0], 1'b0};
    dge      = r2 >= den64;
    xs       = x >>> step;
    ys       = y >>> step;
    atan_v   = atan_q24(step);
    if (z < 0) zc = 32'sd0;
    else if (z > Q24_PI) zc = Q24_PI;
    else zc = z;
    accr     = $signed({acc_q[31], acc_q}) - $signed({zc[31], zc});
    clip     = accr[32:31] == 2'b10;
    sq_start = (state == S_LEN && !any_zero) || state == S_SIN;
    sq_arg   = (state == S_LEN) ? {1'b0, sq[ed], 12'd0}
                                : (64'd1 << 60) - {2'b00, csq};
    case (fcnt)
      2'd0:    pos_raddr = idx[0];
      2'd1:    pos_raddr = idx[1];
      default: pos_raddr = idx[2];
    endcase
    pos_we    = state == S_IDLE && cmd_valid && cmd.kind == K_LOAD;
    acc_we    = pos_we || state == S_ACCWR;
    acc_waddr = (state == S_ACCWR) ? idx[k] : cmd.ia;
    acc_wdata = (state == S_ACCWR) ? (clip ? 32'h8000_0000 : accr[31:0])
                                   : Q24_TWO_PI;
    acc_raddr = (state == S_IDLE) ? cmd.ia : idx[k];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[cmd.ia] <= cmd.pos;
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_q <= acc_mem[acc_raddr];
  end

  assign cmd_ready              = state == S_IDLE;
  assign result.valid           = res_valid;
  assign result.curvature       = res_curv;
  assign result.degenerate_face = res_degen;
  assign result.saturated       = res_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            pend_curv  <= 32'sd0;
            pend_degen <= 1'b0;
            pend_sat   <= 1'b0;
            idx[0]     <= cmd.ia;
            idx[1]     <= cmd.ib;
            idx[2]     <= cmd.ic;
            fcnt       <= 2'd0;
            case (cmd.kind)
              K_READ:  state <= S_RDACC;
              K_FACE:  state <= S_FETCH;
              default: state <= S_DONE;
            endcase
          end
        end
        S_RDACC: begin
          pend_curv <= acc_q;
          state     <= S_DONE;
        end
        S_FETCH: begin
          if (fcnt != 2'd0) p[2'(fcnt - 2'd1)] <= pos_q;
          fcnt <= 2'(fcnt + 2'd1);
          if (fcnt == 2'd3) begin
            ed    <= 2'd0;
            cp    <= 2'd0;
            ph    <= 1'b0;
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (!ph) begin
            prod <= dd;
            ph   <= 1'b1;
          end else begin
            sq[ed] <= ((cp == 2'd0) ? '0 : sq[ed]) + {1'b0, prod};
            ph     <= 1'b0;
            if (cp == 2'd2) begin
              cp <= 2'd0;
              if (ed == 2'd2) begin
                ed    <= 2'd0;
                state <= S_LEN;
              end else begin
                ed <= 2'(ed + 2'd1);
              end
            end else begin
              cp <= 2'(cp + 2'd1);
            end
          end
        end
        S_LEN: begin
          if (any_zero) begin
            pend_degen <= 1'b1;
            state      <= S_DONE;
          end else begin
            state <= S_LENW;
          end
        end
        S_LENW: begin
          if (sq_done) begin
            len[ed] <= sq_root[30:0];
            if (ed == 2'd2) begin
              k     <= 2'd0;
              state <= S_MUL;
            end else begin
              ed    <= 2'(ed + 2'd1);
              state <= S_LEN;
            end
          end
        end
        S_MUL: begin
          den     <= len[kb] * len[kc];
          num_neg <= numv[52];
          n       <= {1'b0, mag[51:0], 11'd0};
          state   <= S_NUM;
        end
        S_NUM: begin
          if (n >= den64) begin
            cmag  <= 31'd1073741824;
            state <= S_SQ;
          end else begin
            r     <= n;
            q     <= '0;
            step  <= 5'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          r    <= dge ? r2 - den64 : r2;
          q    <= {q[28:0], dge};
          step <= 5'(step + 5'd1);
          if (step == 5'(DIV_STEPS - 1)) begin
            cmag  <= {1'b0, q[28:0], dge};
            state <= S_SQ;
          end
        end
        S_SQ: begin
          csq   <= cmag * cmag;
          state <= S_SIN;
        end
        S_SIN: begin
          state <= S_SINW;
        end
        S_SINW: begin
          if (sq_done) begin
            if (num_neg && cmag != '0) begin
              x <= $signed({4'd0, sq_root});
              y <= $signed({5'd0, cmag});
              z <= Q24_HALF_PI;
            end else begin
              x <= $signed({5'd0, cmag});
              y <= $signed({4'd0, sq_root});
              z <= 32'sd0;
            end
            step  <= 5'd0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_v;
          end else if (y < 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_v;
          end
          step <= 5'(step + 5'd1);
          if (step == 5'(CORDIC_STEPS - 1)) state <= S_ACCRD;
        end
        S_ACCRD: begin
          state <= S_ACCWR;
        end
        S_ACCWR: begin
          if (clip) pend_sat <= 1'b1;
          if (k == 2'd2) begin
            state <= S_DONE;
          end else begin
            k     <= nxt(k);
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_curv  <= pend_curv;
            res_degen <= pend_degen;
            res_sat   <= pend_sat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/mesh_angle_defect_curvature.sv
// top level of the angle defect gaussian curvature block
// Each input word gives exactly one result word. A load stores a vertex position
// and sets its accumulator to 2*pi, a read returns the accumulator in Q7.24
// radians, and a face subtracts its three corner angles from its vertices. Loads
// and unused codes go straight to the result state of the back end and reads
// pass through its accumulator read state; a face's time is set by the shared
// square root unit (six uses per face), the one-bit-per-cycle cosine divider and
// the 24-step arctangent rotation per corner. A two-word command queue lets the
// input side keep accepting while a face is worked on, and a result register
// holds the answer until taken. The vertex stores have no reset; reading a vertex
// that was never loaded gives an undefined value.
module mesh_angle_defect_curvature (
  input  logic          clk,
  input  logic          rst,
  madc_item_if.sink     item,
  madc_result_if.source result
);
  import madc_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  madc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  madc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .result    (result)
  );

endmodule

FILE: tb/sv/madc_curvature_checker.sv
// checker that predicts and compares every result word of the angle defect block
`timescale 1ns / 100ps
module madc_curvature_checker (
  input  logic        clk,
  input  logic        rst,
  madc_item_if        item,
  madc_result_if      result,
  output int          errors,
  output int          pending
);
  import madc_pkg::*;

  typedef struct {
    logic signed [31:0] curvature;
    logic               degenerate_face;
    logic               saturated;
  } result_word_t;

  localparam longint ONE_Q30 = 64'sd1073741824;

  int           vertex_pos [MAX_VERTICES][3];
  int           defect_acc [MAX_VERTICES];
  result_word_t expected_words [$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic longint edge_len_sq(input int j, input int k);
    longint s, d;
    s = 0;
    for (int t = 0; t < 3; t++) begin
      d = longint'(vertex_pos[j][t]) - longint'(vertex_pos[k][t]);
      s = s + d * d;
    end
    return s;
  endfunction

  // corner angle in Q7.24 from opposite squared edge sa and adjacent sb, sc
  function automatic longint corner_angle(input longint sa, input longint sb,
                                          input longint sc);
    longint num, c, x, y, z, xs, ys, tmp;
    longint unsigned lb, lc, den, n, r, q;
    num = sb + sc - sa;
    lb  = int_sqrt(longint'(unsigned'(sb)) << 12);
    lc  = int_sqrt(longint'(unsigned'(sc)) << 12);
    den = lb * lc;
    n   = (num < 0 ? -num : num) * 2048;
    if (n >= den) begin
      c = ONE_Q30;
    end else begin
      r = n;
      q = 0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      c = q;
    end
    if (num < 0) c = -c;
    y = int_sqrt(ONE_Q30 * ONE_Q30 - c * c);
    x = c;
    z = 0;
    if (x < 0) begin
      tmp = x;
      x   = y;
      y   = -tmp;
      z   = Q24_HALF_PI;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_q24(i);
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - atan_q24(i);
      end
    end
    if (z < 0) z = 0;
    if (z > Q24_PI) z = Q24_PI;
    return z;
  endfunction

  function automatic bit subtract_angle(input int v, input longint ang);
    longint r;
    r = longint'(defect_acc[v]) - ang;
    if (r < -64'sd2147483648) begin
      defect_acc[v] = 32'h8000_0000;
      return 1'b1;
    end
    defect_acc[v] = int'(r);
    return 1'b0;
  endfunction

  function automatic result_word_t predict_word(input logic [1:0] op,
      input int ia, input int ib, input int ic,
      input logic signed [23:0] x, input logic signed [23:0] y,
      input logic signed [23:0] z);
    result_word_t w;
    longint sa, sb, sc, aa, ab, ac;
    bit s1, s2, s3;
    w = '{32'sd0, 1'b0, 1'b0};
    case (op)
      OP_LOAD: begin
        vertex_pos[ia][0] = x;
        vertex_pos[ia][1] = y;
        vertex_pos[ia][2] = z;
        defect_acc[ia]    = Q24_TWO_PI;
      end
      OP_FACE: begin
        sa = edge_len_sq(ib, ic);
        sb = edge_len_sq(ic, ia);
        sc = edge_len_sq(ia, ib);
        if (sa == 0 || sb == 0 || sc == 0) begin
          w.degenerate_face = 1'b1;
        end else begin
          aa = corner_angle(sa, sb, sc);
          ab = corner_angle(sb, sc, sa);
          ac = corner_angle(sc, sa, sb);
          s1 = subtract_angle(ia, aa);
          s2 = subtract_angle(ib, ab);
          s3 = subtract_angle(ic, ac);
          w.saturated = s1 | s2 | s3;
        end
      end
      OP_READ: w.curvature = defect_acc[ia];
      default: ;
    endcase
    return w;
  endfunction

  initial errors = 0;
  assign pending = expected_words.size();

  always @(posedge clk) begin
    result_word_t want;
    if (!rst) begin
      if (item.valid && item.ready)
        expected_words.push_back(predict_word(item.operation, item.index_a,
            item.index_b, item.index_c, item.coord_x, item.coord_y, item.coord_z));
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (result.curvature !== want.curvature) begin
            $error("curvature expected %0d actual %0d", want.curvature,
                   result.curvature);
            errors++;
          end
          if (result.degenerate_face !== want.degenerate_face) begin
            $error("degenerate_face expected %0b actual %0b",
                   want.degenerate_face, result.degenerate_face);
            errors++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated,
                   result.saturated);
            errors++;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb.sv
// stimulus and verdict for the angle defect curvature block
`timescale 1ns / 100ps
module tb;
  import madc_pkg::*;

  logic clk, rst;
  int   errors, pending;
  int   sent, cycles;
  int   send_idle, recv_idle;
  bit   held_off;
  bit   is_loaded [MAX_VERTICES];
  int   loaded_list [$];

  madc_item_if   item ();
  madc_result_if result ();

  mesh_angle_defect_curvature dut (.clk(clk), .rst(rst), .item(item), .result(result));

  madc_curvature_checker chk (.clk(clk), .rst(rst), .item(item), .result(result),
                              .errors(errors), .pending(pending));

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 5000000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver, with one long hold-off so the command queue fills
  initial begin
    int hold;
    result.ready = 0;
    held_off = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!held_off && sent >= 300) begin
        held_off = 1;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        result.ready = 0;
      end else begin
        result.ready = !rst && ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input int ia, input int ib,
                           input int ic, input int x, input int y, input int z);
    while ($urandom_range(0, 99) < send_idle) begin
      item.valid = 0;
      @(negedge clk);
    end
    item.valid     = 1;
    item.operation = op;
    item.index_a   = ia;
    item.index_b   = ib;
    item.index_c   = ic;
    item.coord_x   = x;
    item.coord_y   = y;
    item.coord_z   = z;
    do @(posedge clk); while (!item.ready);
    @(negedge clk);
    sent++;
    if (sent < 650) begin
      send_idle = 8; recv_idle = 78;
    end else if (sent < 1300) begin
      send_idle = 78; recv_idle = 8;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  endtask

  task automatic load_vertex(input int ia, input int x, input int y, input int z);
    send_word(OP_LOAD, ia, $urandom_range(0, 1023), $urandom_range(0, 1023), x, y, z);
    if (!is_loaded[ia]) begin
      is_loaded[ia] = 1;
      loaded_list.push_back(ia);
    end
  endtask

  function automatic int rand_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return $urandom_range(0, 131071) - 65536;
    if (k < 8) return $urandom_range(0, 16777215) - 8388608;
    return ($urandom_range(0, 8) - 4) * 65536;
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // obtuse face hammered on one vertex until its accumulator clips
  task automatic saturation_burst();
    int a, b, c;
    a = $urandom_range(900, 1023);
    b = (a + 1) % MAX_VERTICES;
    c = (a + 2) % MAX_VERTICES;
    load_vertex(a, 0, 0, 0);
    load_vertex(b, -1048576, 1, 0);
    load_vertex(c, 1048576, 0, 0);
    for (int i = 0; i < 46; i++) send_word(OP_FACE, a, b, c, 0, 0, 0);
    send_word(OP_READ, a, 0, 0, 0, 0, 0);
  endtask

  initial begin
    int k, a, b, c;
    sent = 0;
    send_idle = 8; recv_idle = 78;
    item.valid = 0; item.operation = OP_LOAD;
    item.index_a = 0; item.index_b = 0; item.index_c = 0;
    item.coord_x = 0; item.coord_y = 0; item.coord_z = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed words
    load_vertex(0, 0, 0, 0);
    load_vertex(1023, 8388607, 8388607, 8388607);
    load_vertex(1, -8388608, -8388608, -8388608);
    load_vertex(2, 65536, 0, 0);
    load_vertex(3, 0, 65536, 0);
    load_vertex(4, 65536, 0, 0);
    send_word(OP_FACE, 0, 2, 3, 0, 0, 0);
    send_word(OP_FACE, 0, 1023, 1, 0, 0, 0);
    send_word(OP_FACE, 0, 0, 2, 0, 0, 0);
    send_word(OP_FACE, 0, 2, 4, 0, 0, 0);
    send_word(OP_READ, 0, 0, 0, 0, 0, 0);
    send_word(OP_READ, 1023, 0, 0, 0, 0, 0);
    send_word(OP_READ, 4, 0, 0, 0, 0, 0);
    send_word(2'd3, 1023, 1023, 1023, -1, -1, -1);
    load_vertex(5, 32768, 56756, 0);
    send_word(OP_FACE, 0, 2, 5, 0, 0, 0);
    send_word(OP_READ, 5, 0, 0, 0, 0, 0);
    send_word(OP_READ, 2, 0, 0, 0, 0, 0);

    while (sent < 1950) begin
      k = $urandom_range(0, 99);
      if (k < 2 && sent < 1850) begin
        saturation_burst();
      end else if (k < 27) begin
        a = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
        load_vertex(a, rand_coord(), rand_coord(), rand_coord());
      end else if (k < 70) begin
        a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
        send_word(OP_FACE, a, b, c, rand_coord(), rand_coord(), rand_coord());
      end else if (k < 95) begin
        send_word(OP_READ, pick_loaded(), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
      end else begin
        send_word(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
      end
    end
    item.valid = 0;

    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: mesh_angle_defect_curvature.f
src/madc_pkg.sv
src/madc_if.sv
src/madc_front.sv
src/madc_sqrt.sv
src/madc_back.sv
src/mesh_angle_defect_curvature.sv
tb/sv/madc_curvature_checker.sv
tb/sv/tb.sv
